// ===== src/led_ring_pattern_generator_assert.svh =====
// assertion macros shared by the checker of the led ring pattern generator
// no dependencies; included by the checker file
`ifndef LED_RING_PATTERN_GENERATOR_ASSERT_SVH
`define LED_RING_PATTERN_GENERATOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define LRPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define LRPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lrpg_pkg.sv =====
// package of the led ring pattern generator: types, codes and sizing constants
// no dependencies; used by every module of the block
`default_nettype none

package lrpg_pkg;

  localparam int PIXELS      = 16;
  localparam int MAX_FRAME   = 16;
  localparam int LEN_TOP     = (PIXELS < MAX_FRAME) ? PIXELS : MAX_FRAME;
  localparam int LEN_W       = 5;
  localparam int POS_W       = 4;
  localparam int ELAPSED_W   = 17;
  localparam int CH_W        = 8;
  localparam int COLOR_W     = 24;
  localparam int INTERVAL_W  = 16;
  localparam int STEP_W      = 8;
  localparam int PROD_W      = CH_W + POS_W;
  localparam int NUM_DOTS    = 4;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(500);
  localparam logic [LEN_W-1:0]      RING_LEN_RESET = LEN_W'(16);
  localparam logic [CH_W-1:0]       CHANNEL_MASK   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN  = 2'd0,
    REG_COLOR    = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_RING_LEN = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    PAT_OFF    = 3'd0,
    PAT_ROTATE = 3'd1,
    PAT_FLASH  = 3'd2,
    PAT_FILL   = 3'd3,
    PAT_FADE   = 3'd4,
    PAT_RADAR  = 3'd5,
    PAT_DOUBLE = 3'd6,
    PAT_SCAN   = 3'd7
  } pattern_t;

  typedef struct packed {
    pattern_t                  pattern;
    logic [COLOR_W-1:0]        color;
    logic [INTERVAL_W-1:0]     interval;
    logic [LEN_W-1:0]          ring_length;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    FR_DOTS = 2'd0,
    FR_ALL  = 2'd1,
    FR_FADE = 2'd2
  } frame_kind_t;

  // one frame request handed from the front to the back
  typedef struct packed {
    frame_kind_t                     kind;
    logic [NUM_DOTS-1:0][POS_W-1:0]  dots;
    logic [NUM_DOTS-1:0]             dot_en;
    logic [LEN_W-1:0]                len;
    logic [POS_W-1:0]                pos;
    logic [COLOR_W-1:0]              color;
  } frame_desc_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_EMIT = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/led_ring_pattern_generator.sv =====
// top level of the led ring pattern generator: configuration registers,
// front, frame request queue and back; depends on lrpg_pkg, lrpg_front,
// lrpg_desc_fifo and lrpg_back
// usage:
//   input channel: push in_step_ms (elapsed milliseconds) while in_full is low.
//   result channel: one request per pixel of a frame, pixel 0 first, while
//   out_empty is low; out_pop takes it. out_frame_end marks the last pixel.
//   config: cfg_we writes cfg_data into register cfg_index at once
//   (0 pattern, 1 color, 2 interval, 3 ring length); write only while idle.
// timing:
//   the front takes one input request a cycle as long as the frame queue
//   (two entries) has room; a request that fires a frame is queued there.
//   the back loads a queued frame, runs the bit-serial divider for the fade
//   pattern, then emits one pixel a cycle while its output slot is free.
// reset: elapsed time and ring position clear, pattern off, color black,
//   interval 500, ring length 16; queue and output register empty.
// stall: while out_pop is low a waiting result freezes the output register
//   and the back's emit; the queue then fills, in_full rises, nothing is dropped.
`default_nettype none

module led_ring_pattern_generator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_push,
  output logic                             in_full,
  input  wire [lrpg_pkg::STEP_W-1:0]       in_step_ms,
  output logic                             out_empty,
  input  wire                              out_pop,
  output logic [lrpg_pkg::POS_W-1:0]       out_pixel_index,
  output logic [lrpg_pkg::CH_W-1:0]        out_red,
  output logic [lrpg_pkg::CH_W-1:0]        out_green,
  output logic [lrpg_pkg::CH_W-1:0]        out_blue,
  output logic                             out_frame_end,
  input  wire                              cfg_we,
  input  wire [lrpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lrpg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lrpg_pkg::*;

  cfg_regs_t    cfg_r;
  frame_desc_t  front_desc, back_desc;
  logic         desc_push, desc_pop, q_full, q_empty;
  logic         item_accept;

  // configuration registers, written straight from the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern     <= PAT_OFF;
      cfg_r.color       <= '0;
      cfg_r.interval    <= INTERVAL_RESET;
      cfg_r.ring_length <= RING_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_PATTERN:  cfg_r.pattern     <= pattern_t'(cfg_data[2:0]);
        REG_COLOR:    cfg_r.color       <= cfg_data[COLOR_W-1:0];
        REG_INTERVAL: cfg_r.interval    <= cfg_data[INTERVAL_W-1:0];
        REG_RING_LEN: cfg_r.ring_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input is held off only while the frame queue has no room
  assign in_full     = q_full;
  assign item_accept = in_push && !q_full;

  lrpg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (item_accept),
    .step_ms     (in_step_ms),
    .cfg         (cfg_r),
    .desc_push   (desc_push),
    .desc        (front_desc)
  );

  lrpg_desc_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (desc_push),
    .wr_desc (front_desc),
    .pop     (desc_pop),
    .rd_desc (back_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  lrpg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc_empty      (q_empty),
    .desc            (back_desc),
    .desc_pop        (desc_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_frame_end   (out_frame_end)
  );

endmodule

`default_nettype wire

// ===== src/lrpg_front.sv =====
// front of the led ring pattern generator: time accumulation, frame decision
// and frame request build; depends on lrpg_pkg
`default_nettype none

module lrpg_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          item_accept,
  input  wire [lrpg_pkg::STEP_W-1:0]   step_ms,
  input  lrpg_pkg::cfg_regs_t          cfg,
  output logic                         desc_push,
  output lrpg_pkg::frame_desc_t        desc
);
  import lrpg_pkg::*;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [POS_W-1:0]     position_r, position_nxt;

  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] sum_sat;
  logic                 fire;
  logic [LEN_W-1:0]     len;
  logic [POS_W-1:0]     half;
  logic [POS_W-1:0]     p;
  logic [POS_W-1:0]     t1;
  logic [POS_W-1:0]     f;
  logic [LEN_W-1:0]     p_inc;

  always_comb begin
    sum     = {1'b0, elapsed_r} + (ELAPSED_W+1)'(step_ms);
    sum_sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
    fire    = (cfg.interval != '0) && (sum_sat > ELAPSED_W'(cfg.interval));

    if (cfg.ring_length < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (cfg.ring_length > LEN_W'(LEN_TOP)) begin
      len = LEN_W'(LEN_TOP);
    end else begin
      len = cfg.ring_length;
    end
    half = len[LEN_W-1:1];
    p    = ({1'b0, position_r} >= len) ? '0 : position_r;

    // p < 2*half+1, so two reductions give p mod half
    t1 = (p >= half) ? p - half : p;
    f  = (t1 >= half) ? t1 - half : t1;

    p_inc = {1'b0, p} + LEN_W'(1);
  end

  always_comb begin
    desc.kind   = FR_DOTS;
    desc.dots   = '0;
    desc.dot_en = '0;
    desc.len    = len;
    desc.pos    = p;
    desc.color  = cfg.color;
    unique case (cfg.pattern)
      PAT_OFF: begin
      end
      PAT_ROTATE: begin
        desc.dots[0]   = p;
        desc.dot_en[0] = 1'b1;
      end
      PAT_FLASH: begin
        if (!p[0]) desc.kind = FR_ALL;
      end
      PAT_FILL: begin
        desc.kind = FR_ALL;
      end
      PAT_FADE: begin
        desc.kind = FR_FADE;
      end
      PAT_RADAR: begin
        desc.dots[0] = f;
        desc.dots[1] = half - f;
        desc.dots[2] = POS_W'(len - LEN_W'(f));
        desc.dots[3] = half + f;
        desc.dot_en  = {1'b1, (f != '0), 2'b11};
      end
      PAT_DOUBLE: begin
        desc.dots[0] = f;
        desc.dots[1] = f + half;
        desc.dot_en  = 4'b0011;
      end
      PAT_SCAN: begin
        desc.dots[0] = p;
        desc.dots[1] = POS_W'(len - LEN_W'(p));
        desc.dot_en  = {2'b00, (p != '0), 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    elapsed_nxt  = elapsed_r;
    position_nxt = position_r;
    desc_push    = 1'b0;
    if (item_accept) begin
      if (fire) begin
        elapsed_nxt  = '0;
        position_nxt = (p_inc >= len) ? '0 : p_inc[POS_W-1:0];
        desc_push    = 1'b1;
      end else begin
        elapsed_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      position_r <= '0;
    end else begin
      elapsed_r  <= elapsed_nxt;
      position_r <= position_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/lrpg_desc_fifo.sv =====
// short queue of frame requests between front and back
// depends on lrpg_pkg
`default_nettype none

module lrpg_desc_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  lrpg_pkg::frame_desc_t   wr_desc,
  input  wire                     pop,
  output lrpg_pkg::frame_desc_t   rd_desc,
  output logic                    full,
  output logic                    empty
);
  import lrpg_pkg::*;

  frame_desc_t             entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic                    do_push, do_pop;

  assign full    = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_desc = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/lrpg_back.sv =====
// back of the led ring pattern generator: fade division and per-pixel emit
// into the output register; depends on lrpg_pkg
`default_nettype none

module lrpg_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          desc_empty,
  input  lrpg_pkg::frame_desc_t        desc,
  output logic                         desc_pop,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [lrpg_pkg::POS_W-1:0]   out_pixel_index,
  output logic [lrpg_pkg::CH_W-1:0]    out_red,
  output logic [lrpg_pkg::CH_W-1:0]    out_green,
  output logic [lrpg_pkg::CH_W-1:0]    out_blue,
  output logic                         out_frame_end
);
  import lrpg_pkg::*;

  back_state_t          state_r, state_nxt;
  frame_desc_t          cur_r;
  logic [PROD_W-1:0]    dvd_r [3];
  logic [LEN_W-1:0]     rem_r [3];
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [POS_W-1:0]     pix_r;
  logic                 out_valid_r;

  logic                 load, div_step, emit, last_pix, slot_free, lit;
  logic [CH_W-1:0]      ch_in [3];
  logic [CH_W-1:0]      ch_val [3];
  logic [LEN_W:0]       rem_sh [3];
  logic                 ge [3];

  assign slot_free = !out_valid_r || out_pop;
  assign last_pix  = ({1'b0, pix_r} == cur_r.len - LEN_W'(1));
  assign out_empty = !out_valid_r;

  assign ch_in[0] = desc.color[23:16] & CHANNEL_MASK;
  assign ch_in[1] = desc.color[15:8]  & CHANNEL_MASK;
  assign ch_in[2] = desc.color[7:0]   & CHANNEL_MASK;

  always_comb begin
    lit = (cur_r.kind == FR_ALL) || (cur_r.kind == FR_FADE);
    for (int k = 0; k < NUM_DOTS; k++) begin
      if (cur_r.dot_en[k] && (cur_r.dots[k] == pix_r)) lit = 1'b1;
    end
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem_r[c], dvd_r[c][PROD_W-1]};
      ge[c]     = (rem_sh[c] >= {1'b0, cur_r.len});
    end
    if (cur_r.kind == FR_FADE) begin
      for (int c = 0; c < 3; c++) ch_val[c] = dvd_r[c][CH_W-1:0];
    end else begin
      ch_val[0] = cur_r.color[23:16];
      ch_val[1] = cur_r.color[15:8];
      ch_val[2] = cur_r.color[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    desc_pop  = 1'b0;
    load      = 1'b0;
    div_step  = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!desc_empty) begin
          desc_pop  = 1'b1;
          load      = 1'b1;
          state_nxt = (desc.kind == FR_FADE) ? BK_DIV : BK_EMIT;
        end
      end
      BK_DIV: begin
        div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(PROD_W - 1)) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (last_pix) state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath: load products, restoring division one bit a cycle, pixel walk
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r     <= desc;
      div_cnt_r <= '0;
      pix_r     <= '0;
      for (int c = 0; c < 3; c++) begin
        dvd_r[c] <= PROD_W'(ch_in[c]) * PROD_W'(desc.pos);
        rem_r[c] <= '0;
      end
    end else if (div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= ge[c] ? LEN_W'(rem_sh[c] - {1'b0, cur_r.len}) : LEN_W'(rem_sh[c]);
        dvd_r[c] <= {dvd_r[c][PROD_W-2:0], ge[c]};
      end
    end else if (emit) begin
      pix_r <= pix_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_index <= pix_r;
      out_red         <= lit ? ch_val[0] : '0;
      out_green       <= lit ? ch_val[1] : '0;
      out_blue        <= lit ? ch_val[2] : '0;
      out_frame_end   <= last_pix;
    end
  end

endmodule

`default_nettype wire

// ===== src/lrpg_checker.sv =====
// port-level checker of the led ring pattern generator and its bind
// depends on lrpg_pkg and led_ring_pattern_generator_assert.svh
`default_nettype none

`include "led_ring_pattern_generator_assert.svh"

module lrpg_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              out_empty,
  input  wire                              out_pop,
  input  wire [lrpg_pkg::POS_W-1:0]        out_pixel_index,
  input  wire [lrpg_pkg::CH_W-1:0]         out_red,
  input  wire [lrpg_pkg::CH_W-1:0]         out_green,
  input  wire [lrpg_pkg::CH_W-1:0]         out_blue,
  input  wire                              out_frame_end
);
  import lrpg_pkg::*;

  logic take;
  assign take = out_pop && !out_empty;

  // a waiting result stays put until taken
  `LRPG_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable({out_pixel_index, out_red, out_green, out_blue, out_frame_end}), "result changed while stalled")

  // pixels of a frame come in order
  `LRPG_ASSERT_NEXT(a_pix_order, clk, rst_n, take && !out_frame_end, out_empty || (out_pixel_index == $past(out_pixel_index) + 1'b1), "pixel index out of order")

  // a new frame starts at pixel zero
  `LRPG_ASSERT_NEXT(a_frame_start, clk, rst_n, take && out_frame_end, out_empty || (out_pixel_index == '0), "frame does not start at pixel zero")

  // a ring has at least two pixels
  `LRPG_ASSERT_NOW(a_min_len, clk, rst_n, !out_empty && out_frame_end, out_pixel_index != '0, "frame shorter than two pixels")

endmodule

bind led_ring_pattern_generator lrpg_checker u_lrpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_pixel_index (out_pixel_index),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_frame_end   (out_frame_end)
);

`default_nettype wire

// ===== tb/sv/tb_led_ring_pattern_generator.sv =====
// self-checking testbench of the led ring pattern generator: directed table
// and randomized animation runs under several stall mixes
// depends on lrpg_pkg and the led_ring_pattern_generator top level
module tb_led_ring_pattern_generator;
  import lrpg_pkg::*;

  // clock period is 10; the run limit is given in time units
  localparam int unsigned RUN_LIMIT     = 10_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned ELAPSED_LIMIT = (1 << ELAPSED_W) - 1;
  localparam int unsigned SEGMENTS      = 4;
  localparam int unsigned SEG_STEPS     = 40;

  typedef struct packed {
    logic [POS_W-1:0] idx;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_t;

  // one line of the directed script: a register write or a timing step,
  // optionally with the frame typed in by hand (uniform color, n pixels)
  typedef struct {
    row_kind_t             kind;
    cfg_index_t            reg_idx;
    logic [CFG_DATA_W-1:0] value;
    bit                    fixed;
    int unsigned           n_pix;
    logic [COLOR_W-1:0]    rgb;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [STEP_W-1:0]     in_step_ms;
  logic                  out_empty;
  logic                  out_pop;
  logic [POS_W-1:0]      out_pixel_index;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  out_frame_end;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the registers and of the animation state
  pattern_t              set_pattern;
  logic [COLOR_W-1:0]    set_color;
  logic [INTERVAL_W-1:0] set_interval;
  logic [LEN_W-1:0]      set_ring_len;
  int unsigned           acc_ms;
  int unsigned           ring_pos;

  pixel_t                frame_buf [MAX_FRAME];
  pixel_t                pending_pixels [$];
  script_row_t           script [$];

  // idling of each side, in percent of cycles
  int unsigned           send_gap_pct;
  int unsigned           pop_gap_pct;

  int unsigned           bad_pixels;
  int unsigned           steps_sent;
  int unsigned           frames_due;
  int unsigned           pixels_seen;
  int unsigned           reg_writes;

  led_ring_pattern_generator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_step_ms      (in_step_ms),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_frame_end   (out_frame_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic pixel_t make_pixel(int unsigned idx, logic [COLOR_W-1:0] rgb, bit last);
    pixel_t px;
    px.idx   = idx[POS_W-1:0];
    px.red   = rgb[23:16];
    px.green = rgb[15:8];
    px.blue  = rgb[7:0];
    px.last  = last;
    return px;
  endfunction

  // advance the shadow state by one timing step; when a frame fires, fill
  // frame_buf and return its pixel count, else return zero
  function automatic int unsigned render_frame(logic [STEP_W-1:0] step);
    int unsigned len, half, p, f, i, r, g, b;
    bit          fade;
    bit          lit [MAX_FRAME];
    // elapsed time saturates instead of wrapping
    acc_ms = acc_ms + step;
    if (acc_ms > ELAPSED_LIMIT) acc_ms = ELAPSED_LIMIT;
    // zero interval freezes the animation, time keeps piling up
    if (set_interval == '0 || acc_ms <= set_interval) return 0;
    // excess time beyond the interval is thrown away
    acc_ms = 0;
    // ring length clamps to the usable range
    len = set_ring_len;
    if (len < 2) len = 2;
    if (len > LEN_TOP) len = LEN_TOP;
    half = len / 2;
    // position left over from a longer ring restarts at zero
    p = ring_pos;
    if (p >= len) p = 0;
    fade = 1'b0;
    foreach (lit[k]) lit[k] = 1'b0;
    case (set_pattern)
      PAT_ROTATE: lit[p] = 1'b1;
      PAT_FLASH: begin
        if (p % 2 == 0) for (i = 0; i < len; i++) lit[i] = 1'b1;
      end
      PAT_FILL: for (i = 0; i < len; i++) lit[i] = 1'b1;
      PAT_FADE: fade = 1'b1;
      PAT_RADAR: begin
        f = p % half;
        lit[f] = 1'b1;
        lit[half - f] = 1'b1;
        if (f != 0) lit[len - f] = 1'b1;
        lit[half + f] = 1'b1;
      end
      PAT_DOUBLE: begin
        f = p % half;
        lit[f] = 1'b1;
        lit[f + half] = 1'b1;
      end
      PAT_SCAN: begin
        lit[p] = 1'b1;
        if (p != 0) lit[len - p] = 1'b1;
      end
      default: ;
    endcase
    r = set_color[23:16];
    g = set_color[15:8];
    b = set_color[7:0];
    if (fade) begin
      r = r * p / len;
      g = g * p / len;
      b = b * p / len;
    end
    // dots at or past the ring end never reach the output: only 0..len-1 go out
    for (i = 0; i < len; i++)
      frame_buf[i] = make_pixel(i, (fade || lit[i]) ? {r[7:0], g[7:0], b[7:0]} : '0,
                                i == len - 1);
    ring_pos = (p + 1 >= len) ? 0 : p + 1;
    return len;
  endfunction

  function automatic script_row_t reg_row(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    script_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.value   = v;
    row.fixed   = 1'b0;
    row.n_pix   = 0;
    row.rgb     = '0;
    return row;
  endfunction

  function automatic script_row_t step_row(logic [STEP_W-1:0] step);
    script_row_t row;
    row = reg_row(REG_PATTERN, CFG_DATA_W'(step));
    row.kind = ROW_STEP;
    return row;
  endfunction

  // step whose frame is plain to see: n pixels all of one color
  function automatic script_row_t fixed_row(logic [STEP_W-1:0] step, int unsigned n,
                                            logic [COLOR_W-1:0] rgb);
    script_row_t row;
    row = step_row(step);
    row.fixed = 1'b1;
    row.n_pix = n;
    row.rgb   = rgb;
    return row;
  endfunction

  // register write; cfg_we stays high, the caller lowers it after the group
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_PATTERN:  set_pattern  = pattern_t'(v[2:0]);
      REG_COLOR:    set_color    = v[COLOR_W-1:0];
      REG_INTERVAL: set_interval = v[INTERVAL_W-1:0];
      REG_RING_LEN: set_ring_len = v[LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // hand one timing request to the block and queue the pixels it should cause
  task automatic push_step(logic [STEP_W-1:0] step, bit fixed, int unsigned n,
                           logic [COLOR_W-1:0] rgb);
    int unsigned cnt;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_step_ms <= step;
    @(posedge clk);
    while (in_full) @(posedge clk);
    steps_sent++;
    cnt = render_frame(step);
    if (fixed) begin
      cnt = n;
      for (int unsigned i = 0; i < n; i++) frame_buf[i] = make_pixel(i, rgb, i == n - 1);
    end
    for (int unsigned i = 0; i < cnt; i++) pending_pixels.push_back(frame_buf[i]);
    if (cnt != 0) frames_due++;
  endtask

  // wait for every expected pixel, then let the block settle so that a
  // step still in flight cannot see a register change
  task automatic quiesce();
    in_push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random pop stalls, every taken pixel checked field by field
  initial begin
    pixel_t want;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel %0d arrived with no frame outstanding", out_pixel_index);
          bad_pixels++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_seen++;
          if (out_pixel_index !== want.idx) begin
            $error("pixel_index: expected %0d, got %0d", want.idx, out_pixel_index);
            bad_pixels++;
          end
          if (out_red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_red);
            bad_pixels++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_green);
            bad_pixels++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_blue);
            bad_pixels++;
          end
          if (out_frame_end !== want.last) begin
            $error("frame_end: expected %0d, got %0d", want.last, out_frame_end);
            bad_pixels++;
          end
        end
      end
      out_pop <= rst_n && (pop_gap_pct == 0 || $urandom_range(99) >= pop_gap_pct);
    end
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    script_row_t           row;
    bit                    after_step;
    int unsigned           n_steps;
    logic [CFG_DATA_W-1:0] d;
    logic [STEP_W-1:0]     s;

    rst_n        <= 1'b0;
    in_push      <= 1'b0;
    in_step_ms   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_PATTERN;
    cfg_data     <= '0;
    set_pattern  = PAT_OFF;
    set_color    = '0;
    set_interval = INTERVAL_RESET;
    set_ring_len = RING_LEN_RESET;
    acc_ms       = 0;
    ring_pos     = 0;
    send_gap_pct = 0;
    pop_gap_pct  = 0;
    bad_pixels   = 0;
    steps_sent   = 0;
    frames_due   = 0;
    pixels_seen  = 0;
    reg_writes   = 0;

    // directed script
    // reset defaults: pattern off, interval 500, full ring of 16
    script.push_back(fixed_row(8'd255, 0, '0));
    script.push_back(fixed_row(8'd255, 16, '0));
    script.push_back(fixed_row(8'd0, 0, '0));
    // zero interval holds the frame back while time piles up
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_FILL)));
    script.push_back(reg_row(REG_COLOR, 24'hFFFFFF));
    script.push_back(reg_row(REG_INTERVAL, 24'd0));
    script.push_back(fixed_row(8'd255, 0, '0));
    // smallest interval releases it on a zero step
    script.push_back(reg_row(REG_INTERVAL, 24'd1));
    script.push_back(fixed_row(8'd0, 16, 24'hFFFFFF));
    // ring length below range clamps to two pixels
    script.push_back(reg_row(REG_RING_LEN, 24'd0));
    script.push_back(reg_row(REG_COLOR, 24'h123456));
    script.push_back(fixed_row(8'd2, 2, 24'h123456));
    // ring length above range clamps to sixteen
    script.push_back(reg_row(REG_RING_LEN, 24'd31));
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_ROTATE)));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd255));
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_FLASH)));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_FADE)));
    script.push_back(reg_row(REG_COLOR, 24'hFFFFFF));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    // odd ring for radar
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_RADAR)));
    script.push_back(reg_row(REG_RING_LEN, 24'd7));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    // shrinking the ring strands the position past its end
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_DOUBLE)));
    script.push_back(reg_row(REG_RING_LEN, 24'd1));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_SCAN)));
    script.push_back(reg_row(REG_RING_LEN, 24'd17));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    script.push_back(step_row(8'd2));
    script.push_back(reg_row(REG_INTERVAL, 24'hFFFF));
    script.push_back(fixed_row(8'd255, 0, '0));
    // excess time is dropped: after a fire, exactly the interval is not enough
    script.push_back(reg_row(REG_PATTERN, CFG_DATA_W'(PAT_OFF)));
    script.push_back(reg_row(REG_COLOR, 24'd0));
    script.push_back(reg_row(REG_INTERVAL, 24'd3));
    script.push_back(fixed_row(8'd255, 16, '0));
    script.push_back(fixed_row(8'd3, 0, '0));
    script.push_back(fixed_row(8'd1, 16, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    after_step = 1'b0;
    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_WRITE) begin
        if (after_step) quiesce();
        after_step = 1'b0;
        write_reg(row.reg_idx, row.value);
      end else begin
        cfg_we <= 1'b0;
        push_step(row.value[STEP_W-1:0], row.fixed, row.n_pix, row.rgb);
        after_step = 1'b1;
      end
    end

    // random animation runs: sender idles 10 and receiver 77 percent,
    // then swapped, then neither side idles
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 10 : (ph == 1) ? 77 : 0;
      pop_gap_pct  = (ph == 0) ? 77 : (ph == 1) ? 10 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        quiesce();
        // unused upper data bits are filled with noise
        d = CFG_DATA_W'($urandom);
        d[2:0] = 3'($urandom_range(0, 7));
        write_reg(REG_PATTERN, d);
        case ($urandom_range(0, 5))
          0:       d = 24'h000000;
          1:       d = 24'hFFFFFF;
          default: d = CFG_DATA_W'($urandom);
        endcase
        write_reg(REG_COLOR, d);
        d = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
          0:       d[15:0] = 16'd0;
          1:       d[15:0] = 16'hFFFF;
          2:       d[15:0] = 16'd1;
          default: d[15:0] = 16'($urandom_range(2, 400));
        endcase
        write_reg(REG_INTERVAL, d);
        d = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          d[4:0] = 5'($urandom_range(0, 31));
        end else begin
          d[4:0] = 5'($urandom_range(2, 16));
        end
        write_reg(REG_RING_LEN, d);
        cfg_we <= 1'b0;
        // a frozen animation only gets a short burst
        n_steps = (set_interval == '0) ? 8 : SEG_STEPS;
        for (int k = 0; k < n_steps; k++) begin
          case ($urandom_range(0, 7))
            0:       s = 8'd0;
            1:       s = 8'd255;
            default: s = STEP_W'($urandom_range(0, 255));
          endcase
          push_step(s, 1'b0, 0, '0);
        end
      end
    end

    quiesce();
    $display("covered %0d timing requests and %0d register writes over all eight patterns",
             steps_sent, reg_writes);
    $display("checked %0d pixels in %0d frames under both stall mixes and none",
             pixels_seen, frames_due);
    if (bad_pixels == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lrpg_pkg.sv
src/lrpg_front.sv
src/lrpg_desc_fifo.sv
src/lrpg_back.sv
src/led_ring_pattern_generator.sv
src/lrpg_checker.sv
tb/sv/tb_led_ring_pattern_generator.sv
